// ===== hdl/mlft_pkg.sv =====
// shared types, codes and constants of the mac learning forwarding table
package mlft_pkg;

  localparam int MacW       = 48;
  localparam int PortW      = 7;
  localparam int TimeW      = 32;
  localparam int LifeW      = 16;
  localparam int CntW       = 32;
  localparam int FuncW      = 2;
  localparam int CodeW      = 3;
  localparam int BucketMaxW = 12;
  localparam int MacBytes   = 6;
  localparam int HashMul    = 7;

  localparam int DefHashBuckets = 257;
  localparam int DefProbeSlots  = 5;
  localparam int DefNumPorts    = 128;
  localparam int QueueDepth     = 2;

  localparam logic [LifeW-1:0] LifeReset = 16'd300;

  // operation codes of an input beat
  typedef enum logic [FuncW-1:0] {
    FUNC_FRAME      = 2'd0,
    FUNC_FLUSH_PORT = 2'd1,
    FUNC_FLUSH_ALL  = 2'd2
  } func_e;

  typedef enum logic [CodeW-1:0] {
    DEC_FLOOD_MCAST   = 3'd0,
    DEC_FLOOD_UNKNOWN = 3'd1,
    DEC_FORWARD       = 3'd2,
    DEC_FILTER        = 3'd3,
    DEC_FLUSH_DONE    = 3'd4
  } decision_e;

  typedef enum logic [CodeW-1:0] {
    LRN_NONE      = 3'd0,
    LRN_REFRESHED = 3'd1,
    LRN_MOVED     = 3'd2,
    LRN_NEW_SLOT  = 3'd3,
    LRN_EVICTED   = 3'd4
  } learn_e;

  // classified command handed from front to back
  typedef struct packed {
    func_e                 kind;
    logic [MacW-1:0]       src_mac;
    logic [MacW-1:0]       dst_mac;
    logic [PortW-1:0]      port;
    logic [TimeW-1:0]      now;
    logic [BucketMaxW-1:0] src_base;
    logic [BucketMaxW-1:0] dst_base;
    logic                  src_mcast;
    logic                  dst_mcast;
  } cmd_t;

  // one table slot, expire of zero marks it empty
  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
    logic [TimeW-1:0] expire;
  } entry_t;

endpackage

// ===== hdl/mlft_if.sv =====
// valid/ready channel interfaces of the mac learning forwarding table
interface mlft_in_if;
  logic                        valid;
  logic                        ready;
  logic [mlft_pkg::FuncW-1:0]  func;
  logic [mlft_pkg::MacW-1:0]   src_mac;
  logic [mlft_pkg::MacW-1:0]   dst_mac;
  logic [mlft_pkg::PortW-1:0]  in_port;
  logic [mlft_pkg::TimeW-1:0]  now_sec;
  modport source (output valid, func, src_mac, dst_mac, in_port, now_sec, input ready);
  modport sink (input valid, func, src_mac, dst_mac, in_port, now_sec, output ready);
endinterface

interface mlft_out_if;
  logic                        valid;
  logic                        ready;
  logic [mlft_pkg::CodeW-1:0]  decision;
  logic [mlft_pkg::PortW-1:0]  out_port;
  logic [mlft_pkg::CodeW-1:0]  learn_action;
  logic [mlft_pkg::CntW-1:0]   hit_count;
  logic [mlft_pkg::CntW-1:0]   miss_count;
  modport source (output valid, decision, out_port, learn_action, hit_count, miss_count,
                  input ready);
  modport sink (input valid, decision, out_port, learn_action, hit_count, miss_count,
                output ready);
endinterface

interface mlft_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mlft_pkg::LifeW-1:0]  entry_lifetime;
  modport source (output valid, entry_lifetime, input ready);
  modport sink (input valid, entry_lifetime, output ready);
endinterface

// ===== hdl/mlft_ram.sv =====
// generic single write, single registered read memory
module mlft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mlft_front.sv =====
// front end: accepts beats, drops invalid ones, hashes both macs
module mlft_front #(
  parameter int HASH_BUCKETS = mlft_pkg::DefHashBuckets,
  parameter int NUM_PORTS    = mlft_pkg::DefNumPorts
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mlft_in_if.sink        in_i,
  input  logic           init_done_i,
  output mlft_pkg::cmd_t cmd_o,
  output logic           push_o,
  input  logic           full_i
);
  import mlft_pkg::*;

  localparam int BW  = $clog2(HASH_BUCKETS);
  localparam int VW  = $clog2(8 * HASH_BUCKETS + 256) + 1;
  localparam int KS  = $clog2(8 + 256 / HASH_BUCKETS + 1);
  localparam int StW = $clog2(MacBytes);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  // one hash byte: h*7 + b, then reduced below the bucket count
  function automatic logic [BW-1:0] hash_step(input logic [BW-1:0] h, input logic [7:0] b);
    logic [VW-1:0] v;
    logic [VW-1:0] m;
    v = VW'(h) * VW'(HashMul) + VW'(b);
    for (int k = KS - 1; k >= 0; k--) begin
      m = VW'(HASH_BUCKETS) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[BW-1:0];
  endfunction

  fstate_e          state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [BW-1:0]    hs_q, hs_d, hd_q, hd_d;
  logic [MacW-1:0]  shs_q, shs_d, shd_q, shd_d;
  logic [StW-1:0]   step_q, step_d;
  logic [BW-1:0]    hs_next, hd_next;
  logic             accept;
  logic             port_ok;

  assign in_i.ready = (state_q == F_IDLE) && init_done_i;
  assign accept     = in_i.valid && in_i.ready;
  assign port_ok    = {1'b0, in_i.in_port} < (PortW + 1)'(NUM_PORTS);
  assign hs_next    = hash_step(hs_q, shs_q[MacW-1 -: 8]);
  assign hd_next    = hash_step(hd_q, shd_q[MacW-1 -: 8]);
  assign cmd_o      = cmd_q;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  // classify and hash
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    hs_d    = hs_q;
    hd_d    = hd_q;
    shs_d   = shs_q;
    shd_d   = shd_q;
    step_d  = step_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          cmd_d.src_mac   = in_i.src_mac;
          cmd_d.dst_mac   = in_i.dst_mac;
          cmd_d.port      = in_i.in_port;
          cmd_d.now       = in_i.now_sec;
          cmd_d.src_mcast = in_i.src_mac[MacW-8];
          cmd_d.dst_mcast = in_i.dst_mac[MacW-8];
          cmd_d.src_base  = '0;
          cmd_d.dst_base  = '0;
          hs_d   = '0;
          hd_d   = '0;
          shs_d  = in_i.src_mac;
          shd_d  = in_i.dst_mac;
          step_d = '0;
          case (in_i.func)
            FUNC_FRAME: begin
              cmd_d.kind = FUNC_FRAME;
              if (port_ok) begin
                state_d = F_HASH;
              end
            end
            FUNC_FLUSH_PORT: begin
              cmd_d.kind = FUNC_FLUSH_PORT;
              state_d    = F_PUSH;
            end
            FUNC_FLUSH_ALL: begin
              cmd_d.kind = FUNC_FLUSH_ALL;
              state_d    = F_PUSH;
            end
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_HASH: begin
        hs_d   = hs_next;
        hd_d   = hd_next;
        shs_d  = shs_q << 8;
        shd_d  = shd_q << 8;
        step_d = step_q + 1'b1;
        if (step_q == StW'(MacBytes - 1)) begin
          cmd_d.src_base = BucketMaxW'(hs_next);
          cmd_d.dst_base = BucketMaxW'(hd_next);
          state_d        = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hs_q   <= hs_d;
    hd_q   <= hd_d;
    shs_q  <= shs_d;
    shd_q  <= shd_d;
    step_q <= step_d;
  end

endmodule

// ===== hdl/mlft_queue.sv =====
// short command queue between front and back
module mlft_queue #(
  parameter int DEPTH = mlft_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mlft_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output mlft_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import mlft_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/mlft_back.sv =====
// back end: table probing, learning, lookup, flush sweeps and result register
module mlft_back #(
  parameter int HASH_BUCKETS = mlft_pkg::DefHashBuckets,
  parameter int PROBE_SLOTS  = mlft_pkg::DefProbeSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mlft_pkg::LifeW-1:0]  life_i,
  input  mlft_pkg::cmd_t              cmd_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        init_done_o,
  mlft_out_if.source                  res_o
);
  import mlft_pkg::*;

  localparam int T  = HASH_BUCKETS + PROBE_SLOTS - 1;
  localparam int AW = $clog2(T);
  localparam int SW = $clog2(T + 1);
  localparam int IW = $clog2(PROBE_SLOTS + 1);

  typedef enum logic [5:0] {
    B_INIT  = 6'b000001,
    B_IDLE  = 6'b000010,
    B_FLUSH = 6'b000100,
    B_SRC   = 6'b001000,
    B_DST   = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_e;

  bstate_e           state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [SW-1:0]     sweep_q, sweep_d;
  logic [IW-1:0]     ridx_q, ridx_d;
  logic              ev_q, ev_d;
  logic [AW-1:0]     ea_q;
  logic [AW-1:0]     best_q, best_d;
  logic [TimeW-1:0]  oldest_q, oldest_d;
  decision_e         dec_q, dec_d;
  logic [PortW-1:0]  oport_q, oport_d;
  learn_e            act_q, act_d;
  logic [CntW-1:0]   hits_q, hits_d, misses_q, misses_d;
  logic              ov_q;
  decision_e         o_dec_q;
  logic [PortW-1:0]  o_port_q;
  learn_e            o_act_q;
  logic [CntW-1:0]   o_hits_q, o_misses_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;
  logic              load_out;

  logic [LifeW-1:0]  life_eff;
  logic [TimeW:0]    exp_sum;
  logic [TimeW-1:0]  new_exp;
  logic              is_first, is_last, issue;
  logic              match_s, match_d, take;
  logic [AW-1:0]     cand_best;
  logic [TimeW-1:0]  cand_old;

  mlft_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (T)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // saturating expiry, a zero lifetime counts as one second
  assign life_eff = (life_i == '0) ? LifeW'(1) : life_i;
  assign exp_sum  = {1'b0, cmd_q.now} + (TimeW + 1)'(life_eff);
  assign new_exp  = exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];

  // probe pipeline helpers
  assign issue     = ridx_q < IW'(PROBE_SLOTS);
  assign is_first  = ridx_q == IW'(1);
  assign is_last   = ridx_q == IW'(PROBE_SLOTS);
  assign match_s   = (rd.expire != '0) && (rd.mac == cmd_q.src_mac);
  assign match_d   = (rd.expire != '0) && (rd.mac == cmd_q.dst_mac);
  assign take      = is_first || (rd.expire < oldest_q);
  assign cand_best = take ? ea_q : best_q;
  assign cand_old  = take ? rd.expire : oldest_q;

  assign init_done_o = state_q != B_INIT;

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    sweep_d   = sweep_q;
    ridx_d    = ridx_q;
    ev_d      = 1'b0;
    best_d    = best_q;
    oldest_d  = oldest_q;
    dec_d     = dec_q;
    oport_d   = oport_q;
    act_d     = act_q;
    hits_d    = hits_q;
    misses_d  = misses_q;
    ram_we    = 1'b0;
    ram_waddr = ea_q;
    ram_wdata = '0;
    ram_raddr = ea_q;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      B_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[AW-1:0];
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SW'(T - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          ridx_d  = '0;
          sweep_d = '0;
          act_d   = LRN_NONE;
          oport_d = '0;
          case (cmd_i.kind)
            FUNC_FRAME: begin
              if (!cmd_i.src_mcast) begin
                state_d = B_SRC;
              end else if (!cmd_i.dst_mcast) begin
                state_d = B_DST;
              end else begin
                dec_d   = DEC_FLOOD_MCAST;
                state_d = B_OUT;
              end
            end
            default: state_d = B_FLUSH;
          endcase
        end
      end
      B_FLUSH: begin
        // read one slot a cycle, clear the one read the cycle before if its port matches or all are flushed
        if (sweep_q < SW'(T)) begin
          ram_raddr = sweep_q[AW-1:0];
          sweep_d   = sweep_q + 1'b1;
          ev_d      = 1'b1;
        end
        if (ev_q) begin
          if ((cmd_q.kind == FUNC_FLUSH_ALL) || (rd.port == cmd_q.port)) begin
            ram_we    = 1'b1;
            ram_waddr = ea_q;
          end
          if (ea_q == AW'(T - 1)) begin
            dec_d   = DEC_FLUSH_DONE;
            state_d = B_OUT;
          end
        end
      end
      B_SRC: begin
        if (issue) begin
          ram_raddr = AW'(cmd_q.src_base) + AW'(ridx_q);
          ridx_d    = ridx_q + 1'b1;
          ev_d      = 1'b1;
        end
        if (ev_q) begin
          ram_wdata = '{mac: cmd_q.src_mac, port: cmd_q.port, expire: new_exp};
          if (match_s || is_last) begin
            ram_we = 1'b1;
            ridx_d = '0;
            ev_d   = 1'b0;
            if (match_s) begin
              ram_waddr = ea_q;
              act_d     = (rd.port != cmd_q.port) ? LRN_MOVED : LRN_REFRESHED;
            end else begin
              ram_waddr = cand_best;
              act_d     = (cand_old != '0) ? LRN_EVICTED : LRN_NEW_SLOT;
            end
            if (cmd_q.dst_mcast) begin
              dec_d   = DEC_FLOOD_MCAST;
              state_d = B_OUT;
            end else begin
              state_d = B_DST;
            end
          end else begin
            best_d   = cand_best;
            oldest_d = cand_old;
          end
        end
      end
      B_DST: begin
        if (issue) begin
          ram_raddr = AW'(cmd_q.dst_base) + AW'(ridx_q);
          ridx_d    = ridx_q + 1'b1;
          ev_d      = 1'b1;
        end
        if (ev_q) begin
          if (match_d) begin
            state_d = B_OUT;
            if (cmd_q.now >= rd.expire) begin
              misses_d = misses_q + 1'b1;
              dec_d    = DEC_FLOOD_UNKNOWN;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = ea_q;
              ram_wdata = '{mac: rd.mac, port: rd.port, expire: new_exp};
              if (rd.port != cmd_q.port) begin
                hits_d  = hits_q + 1'b1;
                dec_d   = DEC_FORWARD;
                oport_d = rd.port;
              end else begin
                dec_d = DEC_FILTER;
              end
            end
          end else if (is_last) begin
            misses_d = misses_q + 1'b1;
            dec_d    = DEC_FLOOD_UNKNOWN;
            state_d  = B_OUT;
          end
        end
      end
      B_OUT: begin
        if (!ov_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_INIT;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_INIT;
      sweep_q  <= '0;
      ridx_q   <= '0;
      ev_q     <= 1'b0;
      hits_q   <= '0;
      misses_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      ridx_q   <= ridx_d;
      ev_q     <= ev_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      ov_q     <= load_out || (ov_q && !res_o.ready);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ea_q     <= ram_raddr;
    best_q   <= best_d;
    oldest_q <= oldest_d;
    dec_q    <= dec_d;
    oport_q  <= oport_d;
    act_q    <= act_d;
    if (load_out) begin
      o_dec_q    <= dec_q;
      o_port_q   <= oport_q;
      o_act_q    <= act_q;
      o_hits_q   <= hits_q;
      o_misses_q <= misses_q;
    end
  end

  // result channel
  assign res_o.valid        = ov_q;
  assign res_o.decision     = o_dec_q;
  assign res_o.out_port     = o_port_q;
  assign res_o.learn_action = o_act_q;
  assign res_o.hit_count    = o_hits_q;
  assign res_o.miss_count   = o_misses_q;

endmodule

// ===== hdl/mac_learning_forwarding_table_unit.sv =====
// Ethernet bridge address table with source learning and destination lookup.
// In the front end a frame is accepted, both addresses are hashed one byte a
// cycle, and the command is then pushed into the queue, waiting while it is full.
// In the back end every probe is one read of the single read port of the
// table memory, and a probe that matches early ends its pass sooner.
// Front and back overlap through a two-entry queue. A flush of one port
// or of the whole table sweeps all HASH_BUCKETS+PROBE_SLOTS-1 slots, one a
// cycle. After reset the table is cleared by a pass over all
// HASH_BUCKETS+PROBE_SLOTS-1 slots (261 by default), during which no input
// beat is taken; lifetime writes are taken at any time.
module mac_learning_forwarding_table_unit #(
  parameter int HASH_BUCKETS = mlft_pkg::DefHashBuckets,
  parameter int PROBE_SLOTS  = mlft_pkg::DefProbeSlots,
  parameter int NUM_PORTS    = mlft_pkg::DefNumPorts
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlft_in_if.sink     in_i,
  mlft_cfg_if.sink    cfg_i,
  mlft_out_if.source  res_o
);
  import mlft_pkg::*;

  logic [LifeW-1:0] life_q;
  cmd_t             f_cmd, q_cmd;
  logic             push, full, pop, empty, init_done;

  // lifetime register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q <= LifeReset;
    end else if (cfg_i.valid) begin
      life_q <= cfg_i.entry_lifetime;
    end
  end

  mlft_front #(
    .HASH_BUCKETS (HASH_BUCKETS),
    .NUM_PORTS    (NUM_PORTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .init_done_i (init_done),
    .cmd_o       (f_cmd),
    .push_o      (push),
    .full_i      (full)
  );

  mlft_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .empty_o (empty)
  );

  mlft_back #(
    .HASH_BUCKETS (HASH_BUCKETS),
    .PROBE_SLOTS  (PROBE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .life_i      (life_q),
    .cmd_i       (q_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_done_o (init_done),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/mlft_checker.sv =====
// port-level checks of the result channel, bound to the top level
module mlft_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        valid_i,
  input logic                        ready_i,
  input logic [mlft_pkg::CodeW-1:0]  decision_i,
  input logic [mlft_pkg::PortW-1:0]  out_port_i,
  input logic [mlft_pkg::CodeW-1:0]  learn_action_i,
  input logic [mlft_pkg::CntW-1:0]   hit_count_i
);
  import mlft_pkg::*;

  // a stalled result beat stays valid and keeps its decision and hit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(decision_i) && $stable(hit_count_i))
    else $error("result payload changed while stalled");

  // a port only comes with a forward decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (decision_i != DEC_FORWARD) |-> out_port_i == '0)
    else $error("egress port without forward decision");

  // flush results carry no learning action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (decision_i == DEC_FLUSH_DONE) |-> learn_action_i == LRN_NONE)
    else $error("learning action on flush result");

  // decision and learning codes stay within their defined ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (decision_i <= DEC_FLUSH_DONE) && (learn_action_i <= LRN_EVICTED))
    else $error("undefined result code");

endmodule

bind mac_learning_forwarding_table_unit mlft_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (res_o.valid),
  .ready_i        (res_o.ready),
  .decision_i     (res_o.decision),
  .out_port_i     (res_o.out_port),
  .learn_action_i (res_o.learn_action),
  .hit_count_i    (res_o.hit_count)
);

// ===== tb/tb_top.sv =====
// self-checking testbench of the mac learning forwarding table
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mlft_pkg::*;

  localparam int Buckets = DefHashBuckets;
  localparam int Probes  = DefProbeSlots;
  localparam int Slots   = Buckets + Probes - 1;
  localparam int Limit   = 2000000;

  typedef struct {
    logic [CodeW-1:0] decision;
    logic [PortW-1:0] out_port;
    logic [CodeW-1:0] learn_action;
    logic [CntW-1:0]  hit_count;
    logic [CntW-1:0]  miss_count;
  } verdict_t;

  // scoreboard: table shadow and queue of expected verdicts
  class fwd_table_sb;
    logic [MacW-1:0]  mac [Slots];
    logic [PortW-1:0] port [Slots];
    logic [TimeW-1:0] expire [Slots];
    logic [CntW-1:0]  hits, misses;
    logic [LifeW-1:0] lifetime;
    verdict_t         pending[$];
    int               errors, checked;

    function void clear_all();
      for (int s = 0; s < Slots; s++) begin
        mac[s] = '0; port[s] = '0; expire[s] = '0;
      end
    endfunction

    function int bucket(logic [MacW-1:0] m);
      int unsigned h;
      h = 0;
      for (int k = 0; k < MacBytes; k++) h = h * HashMul + m[47-8*k -: 8];
      return h % Buckets;
    endfunction

    function logic [TimeW-1:0] next_expiry(logic [TimeW-1:0] now);
      logic [TimeW:0] e;
      e = now + ((lifetime == 0) ? 1 : lifetime);
      return e[TimeW] ? '1 : e[TimeW-1:0];
    endfunction

    function logic [CodeW-1:0] learn_src(logic [MacW-1:0] m, logic [PortW-1:0] p,
                                         logic [TimeW-1:0] now);
      int b, best;
      logic [TimeW-1:0] oldest;
      logic [CodeW-1:0] act;
      if (m[40]) return LRN_NONE;
      b = bucket(m); best = b; oldest = expire[b];
      for (int i = 0; i < Probes; i++) begin
        if (expire[b+i] != 0 && mac[b+i] == m) begin
          expire[b+i] = next_expiry(now);
          if (port[b+i] != p) begin
            port[b+i] = p;
            return LRN_MOVED;
          end
          return LRN_REFRESHED;
        end
        if (expire[b+i] < oldest) begin
          oldest = expire[b+i]; best = b + i;
        end
      end
      act = (expire[best] != 0) ? LRN_EVICTED : LRN_NEW_SLOT;
      expire[best] = next_expiry(now); mac[best] = m; port[best] = p;
      return act;
    endfunction

    // note one accepted input beat
    function void note_input(logic [FuncW-1:0] f, logic [MacW-1:0] sm, logic [MacW-1:0] dm,
                             logic [PortW-1:0] p, logic [TimeW-1:0] now);
      verdict_t v;
      int b, hit;
      v = '{default: '0};
      if (f == 2'd3) return;
      if (f == FUNC_FLUSH_PORT) begin
        for (int s = 0; s < Slots; s++)
          if (port[s] == p) begin
            mac[s] = '0; port[s] = '0; expire[s] = '0;
          end
        v.decision = DEC_FLUSH_DONE;
      end else if (f == FUNC_FLUSH_ALL) begin
        clear_all();
        v.decision = DEC_FLUSH_DONE;
      end else begin
        v.learn_action = learn_src(sm, p, now);
        if (dm[40]) v.decision = DEC_FLOOD_MCAST;
        else begin
          b = bucket(dm); hit = -1;
          for (int i = 0; i < Probes; i++)
            if (hit == -1 && expire[b+i] != 0 && mac[b+i] == dm) begin
              if (now >= expire[b+i]) hit = -2;
              else begin
                expire[b+i] = next_expiry(now); hit = b + i;
              end
            end
          if (hit < 0) begin
            misses++; v.decision = DEC_FLOOD_UNKNOWN;
          end else if (port[hit] != p) begin
            hits++; v.decision = DEC_FORWARD; v.out_port = port[hit];
          end else v.decision = DEC_FILTER;
        end
      end
      v.hit_count = hits; v.miss_count = misses;
      pending.push_back(v);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(verdict_t a);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result decision %0d", $realtime, a.decision);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.decision !== e.decision)
        $display("%0t: decision exp %0d got %0d", $realtime, e.decision, a.decision);
      if (a.out_port !== e.out_port)
        $display("%0t: out_port exp %0d got %0d", $realtime, e.out_port, a.out_port);
      if (a.learn_action !== e.learn_action)
        $display("%0t: learn_action exp %0d got %0d", $realtime, e.learn_action,
                 a.learn_action);
      if (a.hit_count !== e.hit_count)
        $display("%0t: hit_count exp %0d got %0d", $realtime, e.hit_count, a.hit_count);
      if (a.miss_count !== e.miss_count)
        $display("%0t: miss_count exp %0d got %0d", $realtime, e.miss_count, a.miss_count);
      if (a.decision !== e.decision || a.out_port !== e.out_port ||
          a.learn_action !== e.learn_action || a.hit_count !== e.hit_count ||
          a.miss_count !== e.miss_count) errors++;
    endfunction
  endclass

  logic clk_i, rst_ni;
  mlft_in_if  in_ch ();
  mlft_cfg_if cfg_ch ();
  mlft_out_if res_ch ();

  mac_learning_forwarding_table_unit dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch.sink), .cfg_i (cfg_ch.sink),
    .res_o (res_ch.source)
  );

  fwd_table_sb sb;
  int unsigned cycle;
  logic [MacW-1:0] pool [16];
  logic [TimeW-1:0] clock_sec;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // result sink with random stalls, sampled at the rising edge
  initial begin
    verdict_t r;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      res_ch.ready = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 20) == 0);
      if ($urandom_range(0, 40) == 0) res_ch.ready = 1'b0;
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        r.decision = res_ch.decision; r.out_port = res_ch.out_port;
        r.learn_action = res_ch.learn_action; r.hit_count = res_ch.hit_count;
        r.miss_count = res_ch.miss_count;
        sb.check_result(r);
      end
    end
  end

  task automatic send_beat(logic [FuncW-1:0] f, logic [MacW-1:0] sm, logic [MacW-1:0] dm,
                           logic [PortW-1:0] p, logic [TimeW-1:0] now);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    in_ch.valid = 1'b1; in_ch.func = f; in_ch.src_mac = sm; in_ch.dst_mac = dm;
    in_ch.in_port = p; in_ch.now_sec = now;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    sb.note_input(f, sm, dm, p, now);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_lifetime(logic [LifeW-1:0] life);
    cfg_ch.valid = 1'b1; cfg_ch.entry_lifetime = life;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.ready) break;
    end
    sb.lifetime = life;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (Slots + 40) @(negedge clk_i);
  endtask

  function logic [MacW-1:0] pick_mac();
    logic [MacW-1:0] m;
    if ($urandom_range(0, 3) != 0) m = pool[$urandom_range(0, 15)];
    else m = MacW'({$urandom, $urandom});
    if ($urandom_range(0, 4) != 0) m[40] = 1'b0;
    return m;
  endfunction

  task automatic random_frames(int n, int tstep);
    logic [FuncW-1:0] f;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      f = (k < 93) ? FUNC_FRAME : (k < 96) ? FUNC_FLUSH_PORT : (k < 97) ? FUNC_FLUSH_ALL : 2'd3;
      clock_sec = clock_sec + $urandom_range(0, tstep);
      send_beat(f, pick_mac(), pick_mac(),
                ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5)),
                clock_sec);
    end
  endtask

  initial begin
    logic [MacW-1:0] a, b;
    sb = new();
    sb.clear_all();
    sb.hits = 0; sb.misses = 0; sb.lifetime = LifeReset;
    cycle = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0; in_ch.func = '0; in_ch.src_mac = '0; in_ch.dst_mac = '0;
    in_ch.in_port = '0; in_ch.now_sec = '0;
    cfg_ch.valid = 1'b0; cfg_ch.entry_lifetime = '0;
    // small pool of addresses so that entries are reused often
    for (int i = 0; i < 16; i++) begin
      pool[i] = MacW'({$urandom, $urandom});
      pool[i][40] = 1'b0;
    end
    // these share bucket zero (7*a + b = 257) so probing and eviction get exercised
    for (int i = 0; i < 7; i++) pool[i] = MacW'({8'(i + 1), 8'(250 - 7 * i)});
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    a = 48'h0000_0000_0001; b = 48'h0200_0000_0002;
    send_beat(FUNC_FRAME, a, b, 7'd1, 32'd10);          // new slot, unknown
    send_beat(FUNC_FRAME, b, a, 7'd2, 32'd11);          // forward to port 1
    send_beat(FUNC_FRAME, a, b, 7'd1, 32'd12);          // refresh, forward
    send_beat(FUNC_FRAME, a, a, 7'd1, 32'd13);          // filter same port
    send_beat(FUNC_FRAME, a, b, 7'd3, 32'd14);          // port moved
    send_beat(FUNC_FRAME, 48'h0100_0000_0000, 48'hFFFF_FFFF_FFFF, 7'd127, 32'd15);
    send_beat(FUNC_FRAME, 48'hFEFF_FFFF_FFFF, 48'h0, 7'd0, 32'hFFFF_FFF0); // saturation
    for (int i = 0; i < 7; i++)                          // probe fill and eviction
      send_beat(FUNC_FRAME, pool[i], pool[(i+1)%7], 7'(i), 32'd20 + i);
    send_beat(FUNC_FRAME, b, a, 7'd4, 32'd5000);         // expired destination
    send_beat(2'd3, a, b, 7'd1, 32'd5001);               // ignored function
    send_beat(FUNC_FLUSH_PORT, '0, '0, 7'd3, 32'd5002);
    send_beat(FUNC_FRAME, b, a, 7'd4, 32'd5003);
    send_beat(FUNC_FLUSH_ALL, '1, '1, 7'd127, '1);
    send_beat(FUNC_FRAME, a, b, 7'd5, '1);
    wait_drained();                                      // sender holds off until drained

    // random phases across several lifetimes
    clock_sec = 32'd100;
    write_lifetime(16'd0);     random_frames(150, 1);  wait_drained();
    write_lifetime(16'd1);     random_frames(150, 2);  wait_drained();
    write_lifetime(16'hFFFF);  clock_sec = 32'hFFFF_0000;
    random_frames(200, 4000);  wait_drained();
    clock_sec = 32'd50;
    write_lifetime(16'd30);    random_frames(250, 8);  wait_drained();
    write_lifetime(16'd300);   random_frames(280, 3);  wait_drained();

    $display("covered %0d results over frames, both flushes and five lifetime settings",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
